// ----- rtl/best_fit_pool_allocator_macros.svh -----
// Assertion macros shared by the allocator checker.
`ifndef BEST_FIT_POOL_ALLOCATOR_MACROS_SVH
`define BEST_FIT_POOL_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BFPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define BFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/bfpa_pkg.sv -----
// Shared types and codes of the best-fit pool allocator.
package bfpa_pkg;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BAD_FREE = 2'd3;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic init;       // reset table to one extent
		logic clr;        // clear one header store entry
		logic latch;      // capture the input item
		logic scan;       // examine slot scan_idx
		logic scan_clr;   // clear scan results
		logic rd_hdr;     // read header store
		logic hdr_wr;     // write header store
		logic rm_a;       // remove slot rm_idx (one shift step)
		logic ins;        // insert one shift step
		logic ld_ins;     // load insert value from split/merge
		logic respond;    // present result
	} ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic is_free;
		logic pre_bad;    // address checks fail before header read
		logic hdr_bad;    // header length or range fails
		logic overlap;    // chunk overlaps a free extent
		logic fit_found;
		logic need_split;
		logic below_f;
		logic above_f;
		logic full;
		logic scan_last;
		logic shift_done;
		logic clr_last;   // last header entry being cleared
	} sts_t;
endpackage

// ----- rtl/best_fit_pool_allocator.sv -----
// Top level of the best-fit pool allocator.
//  channel  | handshake           | payload
//  command  | start / busy        | op, request_bytes, payload_address
//  result   | done (one cycle)    | status, granted_address, granted_bytes
//  config   | cfg_valid/cfg_ready | cfg_data (pool_words)
// An item holds busy through a check, a scan over the free table one slot per
// cycle, header write, up to two removes and an insert, each shifting one slot
// per cycle. A free that merges both sides is the worst case. The result
// follows in the cycle busy drops.
// After reset and after each config write, busy stays high while the header
// store is cleared one entry per cycle.
// Results cannot be stalled; done pulses one cycle with the result.
module best_fit_pool_allocator #(
	parameter int WORD_BYTES = 8,
	parameter int POOL_DEPTH = 1024,
	parameter int FREE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [12:0] request_bytes,
	input  logic [12:0] payload_address,
	output logic        done,
	output logic [1:0]  status,
	output logic [12:0] granted_address,
	output logic [12:0] granted_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	import bfpa_pkg::*;

	ctl_t       ctl;
	sts_t       sts;
	logic [1:0] rm_sel;
	logic [1:0] res_status;

	bfpa_ctrl u_ctrl (
		.clk, .arst_n, .start, .cfg_valid, .busy, .cfg_ready,
		.ctl, .rm_sel, .res_status, .sts
	);

	bfpa_dp #(
		.WORD_BYTES(WORD_BYTES), .POOL_DEPTH(POOL_DEPTH), .FREE_SLOTS(FREE_SLOTS)
	) u_dp (
		.clk, .arst_n, .ctl, .rm_sel, .res_status, .op, .request_bytes,
		.payload_address, .cfg_data, .sts, .done, .status,
		.granted_address, .granted_bytes
	);
endmodule

// ----- rtl/bfpa_ctrl.sv -----
// Sequencer of the allocator: scans, removals and inserts.
module bfpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            cfg_valid,
	output logic            busy,
	output logic            cfg_ready,
	output bfpa_pkg::ctl_t  ctl,
	output logic [1:0]      rm_sel,
	output logic [1:0]      res_status,
	input  bfpa_pkg::sts_t  sts
);
	import bfpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_CHK, S_SCAN, S_DEC, S_HDR, S_RM1, S_RM2, S_INS, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] st_q;
	logic       second_q;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign res_status = st_q;

	always_comb begin
		ctl = '0;
		rm_sel = second_q ? 2'd1 : 2'd0;
		unique case (state_q)
			S_IDLE: begin
				ctl.latch = start;
				ctl.scan_clr = start;
				ctl.init = cfg_valid && !start;
			end
			S_INIT: ctl.clr = 1'b1;
			S_CHK: ctl.rd_hdr = 1'b1;
			S_SCAN: ctl.scan = 1'b1;
			S_DEC: ;
			S_HDR: ctl.hdr_wr = 1'b1;
			S_RM1: ctl.rm_a = 1'b1;
			S_RM2: ctl.rm_a = 1'b1;
			S_INS: ctl.ins = 1'b1;
			S_DONE: ctl.respond = 1'b1;
			default: ;
		endcase
		if (state_q == S_DEC) ctl.ld_ins = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			st_q <= ST_OK;
			second_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHK;
						st_q <= ST_OK;
						second_q <= 1'b0;
					end else if (cfg_valid) state_q <= S_INIT;
				end
				S_INIT: if (sts.clr_last) state_q <= S_IDLE;
				S_CHK: begin
					if (sts.is_free && sts.pre_bad) begin
						st_q <= ST_BAD_FREE;
						state_q <= S_DONE;
					end else state_q <= S_SCAN;
				end
				S_SCAN: if (sts.scan_last) state_q <= S_DEC;
				S_DEC: begin
					if (!sts.is_free) begin
						if (!sts.fit_found) begin
							st_q <= ST_NO_FIT;
							state_q <= S_DONE;
						end else state_q <= S_HDR;
					end else if (sts.hdr_bad || sts.overlap) begin
						st_q <= ST_BAD_FREE;
						state_q <= S_DONE;
					end else if (!sts.below_f && !sts.above_f && sts.full) begin
						st_q <= ST_FULL;
						state_q <= S_DONE;
					end else state_q <= S_HDR;
				end
				S_HDR: begin
					if (!sts.is_free || sts.below_f || sts.above_f) state_q <= S_RM1;
					else state_q <= S_INS;
				end
				S_RM1: begin
					if (sts.shift_done) begin
						if (sts.is_free && sts.below_f && sts.above_f) begin
							second_q <= 1'b1;
							state_q <= S_RM2;
						end else if (sts.is_free || sts.need_split) state_q <= S_INS;
						else state_q <= S_DONE;
					end
				end
				S_RM2: if (sts.shift_done) state_q <= S_INS;
				S_INS: if (sts.shift_done) state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/bfpa_dp.sv -----
// Datapath: free table, header store, scan and shift logic.
module bfpa_dp #(
	parameter int WORD_BYTES = 8,
	parameter int POOL_DEPTH = 1024,
	parameter int FREE_SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bfpa_pkg::ctl_t  ctl,
	input  logic [1:0]      rm_sel,
	input  logic [1:0]      res_status,
	input  logic            op,
	input  logic [12:0]     request_bytes,
	input  logic [12:0]     payload_address,
	input  logic [10:0]     cfg_data,
	output bfpa_pkg::sts_t  sts,
	output logic            done,
	output logic [1:0]      status,
	output logic [12:0]     granted_address,
	output logic [12:0]     granted_bytes
);
	import bfpa_pkg::*;

	localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int SW = $clog2(FREE_SLOTS);
	localparam int CW = $clog2(FREE_SLOTS + 1);
	localparam int LW = AW + 2;            // lengths and sums
	localparam int WSH = $clog2(WORD_BYTES);

	logic [LW-1:0] st_q  [FREE_SLOTS];
	logic [LW-1:0] len_q [FREE_SLOTS];
	logic [CW-1:0] cnt_q;
	logic [10:0]   hdr_mem [POOL_DEPTH];
	logic [10:0]   hdr_rd_q;
	logic [LW-1:0] pool_q;
	logic [AW-1:0] clr_q;

	logic          op_q;
	logic [LW-1:0] chunk_q, h_q;
	logic          pre_bad_q;
	logic [CW-1:0] idx_q;
	logic          fit_q, ovl_q, bel_q, abv_q;
	logic [SW-1:0] fit_idx_q, bel_idx_q, abv_idx_q;
	logic [LW-1:0] fit_s_q, fit_n_q, bel_s_q, bel_n_q, abv_n_q;
	logic [LW-1:0] ins_s_q, ins_n_q, clen_q;
	logic [SW-1:0] rm_a_idx_q, rm_b_idx_q;
	logic          shift_act_q;
	logic [CW-1:0] sh_q, pos_q;
	logic          pos_found_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [12:0]   gaddr_q, gbytes_q;

	logic [11:0]   pw_clamp;
	logic [SW-1:0] sidx, rm_idx;
	logic [LW-1:0] s_i, l_i, len_w;
	logic [LW+1:0] h_full;

	// clamp written pool size
	always_comb begin
		pw_clamp = {1'b0, cfg_data};
		if (cfg_data < 11'd3) pw_clamp = 12'd3;
		if (32'(cfg_data) > POOL_DEPTH) pw_clamp = 12'(POOL_DEPTH);
	end

	assign sidx = idx_q[SW-1:0];
	assign s_i  = st_q[sidx];
	assign l_i  = len_q[sidx];
	assign len_w = LW'(hdr_rd_q);
	assign rm_idx = (rm_sel == 2'd0) ? rm_a_idx_q : rm_b_idx_q;
	assign h_full = (LW+2)'(payload_address >> WSH) - (LW+2)'(1);

	assign sts.is_free    = op_q;
	assign sts.pre_bad    = pre_bad_q;
	assign sts.hdr_bad    = (len_w == '0) || (h_q + len_w > pool_q - LW'(2));
	assign sts.overlap    = ovl_q;
	assign sts.fit_found  = fit_q;
	assign sts.need_split = fit_n_q > chunk_q + LW'(2);
	assign sts.below_f    = bel_q;
	assign sts.above_f    = abv_q;
	assign sts.full       = (cnt_q == CW'(FREE_SLOTS));
	assign sts.scan_last  = (idx_q + CW'(1) >= cnt_q);
	assign sts.shift_done = shift_act_q && ((ctl.rm_a && sh_q + CW'(1) >= cnt_q) ||
		(ctl.ins && pos_found_q && sh_q == pos_q));
	assign sts.clr_last   = (clr_q == AW'(POOL_DEPTH - 1));

	// clearing pass writes one entry a cycle; an alloc writes at the extent start, a free clears its header
	always_ff @(posedge clk) begin
		if (ctl.clr) hdr_mem[clr_q] <= 11'd0;
		else if (ctl.hdr_wr)
			hdr_mem[op_q ? h_q[AW-1:0] : fit_s_q[AW-1:0]] <= op_q ? 11'd0 : clen_q[10:0];
		if (ctl.rd_hdr) hdr_rd_q <= hdr_mem[h_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(1);
			st_q[0] <= LW'(1);
			len_q[0] <= LW'((POOL_DEPTH < 1024) ? POOL_DEPTH : 1024) - LW'(3);
			pool_q <= LW'((POOL_DEPTH < 1024) ? POOL_DEPTH : 1024);
			clr_q <= '0;
			done_q <= 1'b0;
			shift_act_q <= 1'b0;
		end else begin
			done_q <= ctl.respond;
			if (ctl.init) begin
				pool_q <= LW'(pw_clamp);
				cnt_q <= CW'(1);
				st_q[0] <= LW'(1);
				len_q[0] <= LW'(pw_clamp) - LW'(3);
				clr_q <= '0;
			end
			if (ctl.clr) clr_q <= clr_q + AW'(1);
			if (ctl.latch) begin
				op_q <= op;
				chunk_q <= LW'(({1'b0, request_bytes} + 14'(WORD_BYTES - 1)) >> WSH) + LW'(1);
				h_q <= LW'(h_full);
				pre_bad_q <= (payload_address[WSH-1:0] != '0) ||
					(payload_address < 13'(WORD_BYTES)) || (h_full < (LW+2)'(1)) ||
					(h_full >= (LW+2)'(pool_q));
				idx_q <= '0;
				fit_q <= 1'b0; ovl_q <= 1'b0; bel_q <= 1'b0; abv_q <= 1'b0;
				shift_act_q <= 1'b0;
			end
			if (ctl.scan && idx_q < cnt_q) begin
				idx_q <= idx_q + CW'(1);
				if (!op_q) begin
					if (!fit_q && l_i >= chunk_q) begin
						fit_q <= 1'b1; fit_idx_q <= sidx;
						fit_s_q <= s_i; fit_n_q <= l_i;
					end
				end else begin
					if (l_i != '0 && h_q < s_i + l_i && s_i < h_q + len_w) ovl_q <= 1'b1;
					if (!bel_q && s_i + l_i == h_q) begin
						bel_q <= 1'b1; bel_idx_q <= sidx; bel_s_q <= s_i; bel_n_q <= l_i;
					end
					if (!abv_q && s_i == h_q + len_w) begin
						abv_q <= 1'b1; abv_idx_q <= sidx; abv_n_q <= l_i;
					end
				end
			end
			if (ctl.ld_ins) begin
				if (!op_q) begin
					clen_q <= (fit_n_q > chunk_q + LW'(2)) ? chunk_q : fit_n_q;
					ins_s_q <= fit_s_q + chunk_q;
					ins_n_q <= fit_n_q - chunk_q;
					rm_a_idx_q <= fit_idx_q;
				end else begin
					clen_q <= len_w;
					ins_s_q <= bel_q ? bel_s_q : h_q;
					ins_n_q <= len_w + (bel_q ? bel_n_q : '0) + (abv_q ? abv_n_q : '0);
					// remove higher index first
					if (bel_q && abv_q) begin
						rm_a_idx_q <= (bel_idx_q > abv_idx_q) ? bel_idx_q : abv_idx_q;
						rm_b_idx_q <= (bel_idx_q > abv_idx_q) ? abv_idx_q : bel_idx_q;
					end else rm_a_idx_q <= bel_q ? bel_idx_q : abv_idx_q;
				end
			end
			// remove: shift down one slot per cycle from rm_idx
			if (ctl.rm_a) begin
				if (!shift_act_q) begin
					shift_act_q <= 1'b1;
					sh_q <= CW'(rm_idx);
				end else if (sh_q + CW'(1) >= cnt_q) begin
					cnt_q <= cnt_q - CW'(1);
					shift_act_q <= 1'b0;
				end else begin
					st_q[sh_q[SW-1:0]] <= st_q[sh_q[SW-1:0] + SW'(1)];
					len_q[sh_q[SW-1:0]] <= len_q[sh_q[SW-1:0] + SW'(1)];
					sh_q <= sh_q + CW'(1);
				end
			end
			// insert: find position scanning up, then shift up from the top
			if (ctl.ins) begin
				if (!shift_act_q) begin
					shift_act_q <= 1'b1;
					pos_q <= '0;
					pos_found_q <= 1'b0;
					sh_q <= cnt_q;
				end else if (!pos_found_q) begin
					if (pos_q < cnt_q && len_q[pos_q[SW-1:0]] < ins_n_q) pos_q <= pos_q + CW'(1);
					else pos_found_q <= 1'b1;
				end else if (sh_q == pos_q) begin
					st_q[pos_q[SW-1:0]] <= ins_s_q;
					len_q[pos_q[SW-1:0]] <= ins_n_q;
					cnt_q <= cnt_q + CW'(1);
					shift_act_q <= 1'b0;
				end else begin
					st_q[sh_q[SW-1:0]] <= st_q[sh_q[SW-1:0] - SW'(1)];
					len_q[sh_q[SW-1:0]] <= len_q[sh_q[SW-1:0] - SW'(1)];
					sh_q <= sh_q - CW'(1);
				end
			end
			if (ctl.respond) begin
				status_q <= res_status;
				if (res_status != ST_OK) begin
					gaddr_q <= '0; gbytes_q <= '0;
				end else if (!op_q) begin
					gaddr_q <= 13'((13'(fit_s_q) + 13'd1) << WSH);
					gbytes_q <= 13'(13'(clen_q) << WSH);
				end else begin
					gaddr_q <= '0;
					gbytes_q <= 13'(13'(clen_q) << WSH);
				end
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign granted_address = gaddr_q;
	assign granted_bytes = gbytes_q;
endmodule

// ----- rtl/bfpa_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
`include "best_fit_pool_allocator_macros.svh"
module bfpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [12:0] granted_address,
	input logic [12:0] granted_bytes,
	input logic        cfg_ready
);
	import bfpa_pkg::*;

	`BFPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept not busy")
	`BFPA_ASSERT_IMP(a_done_busy, clk, arst_n, done, !busy, "done while busy")
	`BFPA_ASSERT_IMP(a_err_zero, clk, arst_n, done && status != ST_OK,
		granted_address == 13'd0 && granted_bytes == 13'd0, "error with payload")
	`BFPA_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_ready, !busy, "cfg ready while busy")
endmodule

bind best_fit_pool_allocator bfpa_checker u_chk (.*);
